[rtl/mct_pkg.sv]
// ----------------------------------------------------------------------------
// mct_pkg
// Shared types, constants and codes for the MIDI clock tempo tracker.
// ----------------------------------------------------------------------------
package mct_pkg;

  localparam int PPQ_DEFAULT   = 24;
  localparam int FRAC_DEFAULT  = 8;
  localparam int TIMER_DEFAULT = 32;

  localparam int AVG_W  = 40;
  localparam int TPS_W  = 27;
  localparam int WIN_W  = 8;
  localparam int NEED_W = 3;
  localparam int BPM_W  = 10;
  localparam int CIDX_W = 2;

  localparam logic [AVG_W-1:0] AVG_MAX = {AVG_W{1'b1}};
  localparam logic [BPM_W-1:0] BPM_MAX = {BPM_W{1'b1}};

  localparam logic [7:0] MIDI_CLOCK = 8'hF8;
  localparam logic [7:0] MIDI_START = 8'hFA;

  localparam logic ACT_TICK = 1'b0;
  localparam logic ACT_BYTE = 1'b1;

  localparam logic EV_TEMPO = 1'b0;
  localparam logic EV_START = 1'b1;

  localparam logic [CIDX_W-1:0] REG_TPS    = 2'd0;
  localparam logic [CIDX_W-1:0] REG_WINDOW = 2'd1;
  localparam logic [CIDX_W-1:0] REG_NEEDED = 2'd2;

  localparam logic [TPS_W-1:0]  TPS_RESET    = 27'd1000000;
  localparam logic [WIN_W-1:0]  WINDOW_RESET = 8'd5;
  localparam logic [NEED_W-1:0] NEEDED_RESET = 3'd4;

  typedef struct packed {
    logic [TPS_W-1:0]  tps;
    logic [WIN_W-1:0]  window;
    logic [NEED_W-1:0] needed;
  } cfg_t;

  typedef struct packed {
    logic             done;
    logic [BPM_W-1:0] bpm;
  } div_res_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_START,
    ST_WAIT
  } top_state_t;

  typedef enum logic [1:0] {
    DV_IDLE,
    DV_CHECK,
    DV_RUN,
    DV_DONE
  } div_state_t;

endpackage

[rtl/mct_cfg.sv]
// ----------------------------------------------------------------------------
// mct_cfg
// Configuration register file: decodes the write channel into the tick
// rate, tempo window and stability count registers.
// ----------------------------------------------------------------------------
module mct_cfg (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [mct_pkg::CIDX_W-1:0] cfg_index,
  input  logic [31:0]               cfg_data,
  output mct_pkg::cfg_t             cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.tps    <= mct_pkg::TPS_RESET;
      cfg.window <= mct_pkg::WINDOW_RESET;
      cfg.needed <= mct_pkg::NEEDED_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        mct_pkg::REG_TPS:    cfg.tps    <= cfg_data[mct_pkg::TPS_W-1:0];
        mct_pkg::REG_WINDOW: cfg.window <= cfg_data[mct_pkg::WIN_W-1:0];
        mct_pkg::REG_NEEDED: cfg.needed <= cfg_data[mct_pkg::NEED_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

[rtl/mct_div.sv]
// ----------------------------------------------------------------------------
// mct_div
// Iterative restoring divider with a shared compare-subtract unit. Yields
// floor(num / den) saturated to the tempo range, or the maximum on zero den.
// ----------------------------------------------------------------------------
module mct_div #(
  parameter int NUM_W = 49,
  parameter int DEN_W = 45
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [NUM_W-1:0]     num,
  input  logic [DEN_W-1:0]     den,
  output mct_pkg::div_res_t    res
);

  localparam int SH_W  = DEN_W + mct_pkg::BPM_W;
  localparam int CMP_W = (NUM_W > SH_W) ? NUM_W : SH_W;
  localparam int CNT_W = $clog2(mct_pkg::BPM_W);

  mct_pkg::div_state_t state, state_next;

  logic [CMP_W-1:0]         rem;
  logic [CMP_W-1:0]         dsh;
  logic [mct_pkg::BPM_W-1:0] quo;
  logic [CNT_W-1:0]         cnt;
  logic                     zero;
  logic                     ge;

  assign ge = (rem >= dsh);

  always_comb begin
    state_next = state;
    unique case (state)
      mct_pkg::DV_IDLE:  if (start) state_next = mct_pkg::DV_CHECK;
      mct_pkg::DV_CHECK: state_next = (zero || ge) ? mct_pkg::DV_DONE : mct_pkg::DV_RUN;
      mct_pkg::DV_RUN: begin
        if (cnt == CNT_W'(mct_pkg::BPM_W - 1)) state_next = mct_pkg::DV_DONE;
      end
      mct_pkg::DV_DONE:  state_next = mct_pkg::DV_IDLE;
      default:           state_next = mct_pkg::DV_IDLE;
    endcase
  end

  always_comb begin
    res.done = (state == mct_pkg::DV_DONE);
    res.bpm  = quo;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mct_pkg::DV_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      mct_pkg::DV_IDLE: begin
        if (start) begin
          rem  <= CMP_W'(num);
          dsh  <= CMP_W'(den) << mct_pkg::BPM_W;
          zero <= (den == '0);
        end
      end
      mct_pkg::DV_CHECK: begin
        cnt <= '0;
        if (zero || ge) begin
          quo <= mct_pkg::BPM_MAX;
        end else begin
          quo <= '0;
          dsh <= dsh >> 1;
        end
      end
      mct_pkg::DV_RUN: begin
        if (ge) rem <= rem - dsh;
        quo <= {quo[mct_pkg::BPM_W-2:0], ge};
        dsh <= dsh >> 1;
        cnt <= cnt + 1'b1;
      end
      default: ;
    endcase
  end

endmodule

[rtl/midi_clock_tempo_tracker.sv]
// ----------------------------------------------------------------------------
// midi_clock_tempo_tracker
// Tracks the tempo of a MIDI clock stream from time-base ticks and reports
// stable tempo changes and start bytes.
// ----------------------------------------------------------------------------
// A tick word and any byte other than the last clock of a group are taken
// without leaving idle; a start byte writes its result to the output register
// at once. The clock byte that completes a group of PULSES_PER_QUARTER pulses
// keeps the block busy: it forms PULSES_PER_QUARTER times the average, hands
// it to the shared compare-subtract divider, which runs a range check and ten
// restoring steps, and then merges the new tempo into the smoothed value and
// updates the stability count. When the average is zero or the tempo
// saturates, the divider skips its steps.
// A word is taken only while the output register is empty or being read.
module midi_clock_tempo_tracker #(
  parameter int PULSES_PER_QUARTER = mct_pkg::PPQ_DEFAULT,
  parameter int FRACTION_BITS      = mct_pkg::FRAC_DEFAULT,
  parameter int TIMER_BITS         = mct_pkg::TIMER_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        action,
  input  logic [7:0]                  midi_byte,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        event_kind,
  output logic [mct_pkg::BPM_W-1:0]   tempo_bpm,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [mct_pkg::CIDX_W-1:0]  cfg_index,
  input  logic [31:0]                 cfg_data
);

  localparam int PC_W  = (PULSES_PER_QUARTER > 1) ? $clog2(PULSES_PER_QUARTER) : 1;
  localparam int PPQ_W = $clog2(PULSES_PER_QUARTER + 1);
  localparam int DEN_W = mct_pkg::AVG_W + PPQ_W;
  localparam int NUM_W = mct_pkg::TPS_W + 6 + FRACTION_BITS;
  localparam int SW    = (TIMER_BITS + FRACTION_BITS > mct_pkg::AVG_W + 1) ?
                         (TIMER_BITS + FRACTION_BITS) : (mct_pkg::AVG_W + 1);
  localparam int BW    = mct_pkg::BPM_W;

  mct_pkg::cfg_t       cfg;
  mct_pkg::div_res_t   div_res;
  mct_pkg::top_state_t state, state_next;

  logic [TIMER_BITS-1:0]        ticks;
  logic [mct_pkg::AVG_W-1:0]    avg;
  logic [PC_W-1:0]              pulse_count;
  logic [BW-1:0]                smoothed;
  logic [BW-1:0]                previous;
  logic [mct_pkg::NEED_W-1:0]   stable;
  logic [DEN_W-1:0]             den;

  logic                         accept;
  logic                         is_clock;
  logic                         is_start;
  logic                         div_start;
  logic                         out_load;
  logic [SW-1:0]                wide;
  logic [mct_pkg::AVG_W-1:0]    sample;
  logic [mct_pkg::AVG_W:0]      sum;
  logic [mct_pkg::AVG_W-1:0]    avg_next;
  logic [PC_W:0]                pc_inc;
  logic                         group_end;
  logic [32:0]                  tps60;
  logic [NUM_W-1:0]             num;
  logic [BW-1:0]                bpm;
  logic [BW-1:0]                diff;
  logic [BW:0]                  mid_sum;
  logic [BW-1:0]                smoothed_next;
  logic [mct_pkg::NEED_W-1:0]   stable_bump;
  logic [mct_pkg::NEED_W-1:0]   stable_next;
  logic                         report;

  mct_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  mct_div #(
    .NUM_W (NUM_W),
    .DEN_W (DEN_W)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (num),
    .den   (den),
    .res   (div_res)
  );

  assign accept   = in_valid && in_ready;
  assign is_clock = (action == mct_pkg::ACT_BYTE) && (midi_byte == mct_pkg::MIDI_CLOCK);
  assign is_start = (action == mct_pkg::ACT_BYTE) && (midi_byte == mct_pkg::MIDI_START);

  // interval sample and running average
  always_comb begin
    wide      = SW'(ticks) << FRACTION_BITS;
    sample    = (wide > SW'(mct_pkg::AVG_MAX)) ? mct_pkg::AVG_MAX
                                               : wide[mct_pkg::AVG_W-1:0];
    sum       = {1'b0, avg} + {1'b0, sample};
    avg_next  = (pulse_count == '0) ? sample : sum[mct_pkg::AVG_W:1];
    pc_inc    = {1'b0, pulse_count} + 1'b1;
    group_end = (pc_inc >= (PC_W + 1)'(PULSES_PER_QUARTER));
  end

  // numerator: ticks_per_second * 60 scaled by the fraction bits
  always_comb begin
    tps60 = {cfg.tps, 6'd0} - {4'd0, cfg.tps, 2'd0};
    num   = NUM_W'(tps60) << FRACTION_BITS;
  end

  // smoothing and stability
  always_comb begin
    bpm           = div_res.bpm;
    diff          = (smoothed > bpm) ? (smoothed - bpm) : (bpm - smoothed);
    mid_sum       = {1'b0, smoothed} + {1'b0, bpm} + 1'b1;
    smoothed_next = (diff < BW'(cfg.window)) ? mid_sum[BW:1] : bpm;
    if (previous == smoothed_next) begin
      stable_bump = (stable == '1) ? stable : stable + 1'b1;
    end else begin
      stable_bump = '0;
    end
    report      = (stable_bump == cfg.needed);
    stable_next = report ? '0 : stable_bump;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      mct_pkg::ST_IDLE:  if (accept && is_clock && group_end) state_next = mct_pkg::ST_MUL;
      mct_pkg::ST_MUL:   state_next = mct_pkg::ST_START;
      mct_pkg::ST_START: state_next = mct_pkg::ST_WAIT;
      mct_pkg::ST_WAIT:  if (div_res.done) state_next = mct_pkg::ST_IDLE;
      default:           state_next = mct_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = (state == mct_pkg::ST_IDLE) && (!out_valid || out_ready);
    div_start = (state == mct_pkg::ST_START);
    out_load  = ((state == mct_pkg::ST_IDLE) && accept && is_start) ||
                ((state == mct_pkg::ST_WAIT) && div_res.done && report);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mct_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ticks       <= '0;
      avg         <= '0;
      pulse_count <= '0;
      smoothed    <= '0;
      previous    <= '0;
      stable      <= '0;
    end else begin
      case (state)
        mct_pkg::ST_IDLE: begin
          if (accept) begin
            if (action == mct_pkg::ACT_TICK) begin
              if (ticks != '1) ticks <= ticks + 1'b1;
            end else if (is_clock) begin
              ticks       <= '0;
              avg         <= avg_next;
              pulse_count <= group_end ? '0 : pc_inc[PC_W-1:0];
            end else if (is_start) begin
              event_kind <= mct_pkg::EV_START;
              tempo_bpm  <= '0;
            end
          end
        end
        mct_pkg::ST_MUL: begin
          den <= DEN_W'(avg) * DEN_W'(PULSES_PER_QUARTER);
        end
        mct_pkg::ST_WAIT: begin
          if (div_res.done) begin
            smoothed <= smoothed_next;
            previous <= smoothed_next;
            stable   <= stable_next;
            if (report) begin
              event_kind <= mct_pkg::EV_TEMPO;
              tempo_bpm  <= smoothed_next;
            end
          end
        end
        default: ;
      endcase
    end
  end

endmodule

[sim/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the MIDI clock tempo tracker. Tick and MIDI byte
// words go in over a valid/ready channel. A tempo model in the bench tracks
// every accepted word and queues the tempo and start events it predicts.
// Each event read from the block is compared with the oldest queued one.
// Stimulus: short directed checks, then clock groups at random intervals
// under several register settings, with random stalls on both sides and one
// long output hold-off.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int PPQ          = mct_pkg::PPQ_DEFAULT;
  localparam int FRAC         = mct_pkg::FRAC_DEFAULT;
  localparam int STALL_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 24;
  localparam int HOLD_CYCLES  = 300;
  localparam logic [mct_pkg::CIDX_W-1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    logic                      kind;
    logic [mct_pkg::BPM_W-1:0] bpm;
  } tempo_event_t;

  logic                         clk;
  logic                         rst        = 1'b1;
  logic                         in_valid   = 1'b0;
  logic                         in_ready;
  logic                         action     = mct_pkg::ACT_TICK;
  logic [7:0]                   midi_byte  = 8'h00;
  logic                         out_valid;
  logic                         out_ready  = 1'b0;
  logic                         event_kind;
  logic [mct_pkg::BPM_W-1:0]    tempo_bpm;
  logic                         cfg_valid  = 1'b0;
  logic                         cfg_ready;
  logic [mct_pkg::CIDX_W-1:0]   cfg_index  = mct_pkg::REG_TPS;
  logic [31:0]                  cfg_data   = '0;

  midi_clock_tempo_tracker dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .action     (action),
    .midi_byte  (midi_byte),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .event_kind (event_kind),
    .tempo_bpm  (tempo_bpm),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // tempo model state
  mct_pkg::cfg_t                     rate_cfg;
  logic [mct_pkg::TIMER_DEFAULT-1:0] tick_count;
  logic [mct_pkg::AVG_W-1:0]         interval_avg;
  int                                pulse_idx;
  logic [mct_pkg::BPM_W-1:0]         smooth_bpm;
  logic [mct_pkg::BPM_W-1:0]         last_bpm;
  logic [mct_pkg::NEED_W-1:0]        steady_groups;

  tempo_event_t expected_events[$];
  tempo_event_t oldest_event;
  int           errors        = 0;
  int           words_sent    = 0;
  int           tx_idle_pct   = 0;
  int           rx_idle_pct   = 0;
  int           hold_left     = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void reset_tempo_model();
    rate_cfg      = '{tps: mct_pkg::TPS_RESET, window: mct_pkg::WINDOW_RESET,
                      needed: mct_pkg::NEEDED_RESET};
    tick_count    = '0;
    interval_avg  = '0;
    pulse_idx     = 0;
    smooth_bpm    = '0;
    last_bpm      = '0;
    steady_groups = '0;
  endfunction

  function automatic void queue_event(tempo_event_t ev);
    expected_events.insert(expected_events.size(), ev);
  endfunction

  function automatic void apply_register(logic [mct_pkg::CIDX_W-1:0] idx, logic [31:0] data);
    case (idx)
      mct_pkg::REG_TPS: begin
        rate_cfg.tps = data[mct_pkg::TPS_W-1:0];
      end
      mct_pkg::REG_WINDOW: begin
        rate_cfg.window = data[mct_pkg::WIN_W-1:0];
      end
      mct_pkg::REG_NEEDED: begin
        rate_cfg.needed = data[mct_pkg::NEED_W-1:0];
      end
      default: begin
      end
    endcase
  endfunction

  function automatic logic [mct_pkg::BPM_W-1:0] bpm_from_interval(
      logic [mct_pkg::AVG_W-1:0] avg);
    logic [63:0] num;
    logic [63:0] den;
    logic [63:0] quo;
    if (avg == '0) return mct_pkg::BPM_MAX;
    num = (64'(rate_cfg.tps) * 64'd60) << FRAC;
    den = 64'(PPQ) * 64'(avg);
    quo = num / den;
    if (quo > 64'(mct_pkg::BPM_MAX)) return mct_pkg::BPM_MAX;
    return quo[mct_pkg::BPM_W-1:0];
  endfunction

  function automatic void take_clock_pulse();
    logic [63:0]               sample;
    logic [63:0]               sum;
    logic [mct_pkg::BPM_W-1:0] bpm;
    tempo_event_t              ev;
    int                        s;
    int                        b;
    int                        diff;
    sample = 64'(tick_count) << FRAC;
    if (sample > 64'(mct_pkg::AVG_MAX)) sample = 64'(mct_pkg::AVG_MAX);
    tick_count = '0;
    pulse_idx++;
    if (pulse_idx == 1) interval_avg = mct_pkg::AVG_W'(sample);
    sum = 64'(interval_avg) + sample;
    interval_avg = mct_pkg::AVG_W'(sum >> 1);
    if (pulse_idx >= PPQ) begin
      pulse_idx = 0;
      bpm = bpm_from_interval(interval_avg);
      s = smooth_bpm;
      b = bpm;
      diff = (s > b) ? s - b : b - s;
      if (diff < int'(rate_cfg.window)) smooth_bpm = mct_pkg::BPM_W'((s + b + 1) >> 1);
      else smooth_bpm = bpm;
      if (last_bpm == smooth_bpm) begin
        if (steady_groups != 3'd7) steady_groups++;
      end else begin
        steady_groups = '0;
      end
      if (steady_groups == rate_cfg.needed) begin
        steady_groups = '0;
        ev.kind = mct_pkg::EV_TEMPO;
        ev.bpm  = smooth_bpm;
        queue_event(ev);
      end
      last_bpm = smooth_bpm;
    end
  endfunction

  function automatic void track_word(logic act, logic [7:0] b);
    tempo_event_t ev;
    if (act == mct_pkg::ACT_TICK) begin
      if (tick_count != '1) tick_count++;
    end else if (b == mct_pkg::MIDI_CLOCK) begin
      take_clock_pulse();
    end else if (b == mct_pkg::MIDI_START) begin
      ev.kind = mct_pkg::EV_START;
      ev.bpm  = '0;
      queue_event(ev);
    end
  endfunction

  // predict on accepted words, check each event read out
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) apply_register(cfg_index, cfg_data);
      if (in_valid && in_ready) track_word(action, midi_byte);
      if (out_valid && out_ready) begin
        if (expected_events.size() == 0) begin
          $error("unexpected event: event_kind %0d, tempo_bpm %0d", event_kind, tempo_bpm);
          errors++;
        end else begin
          oldest_event = expected_events.pop_front();
          if (event_kind !== oldest_event.kind) begin
            $error("event_kind: expected %0d, got %0d", oldest_event.kind, event_kind);
            errors++;
          end
          if (tempo_bpm !== oldest_event.bpm) begin
            $error("tempo_bpm: expected %0d, got %0d", oldest_event.bpm, tempo_bpm);
            errors++;
          end
        end
      end
    end
  end

  // receiver: random stalls, plus a counted hold-off on request
  initial begin
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  initial begin : watchdog
    int stall;
    stall = 0;
    while (stall < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        stall = 0;
      else
        stall++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  task automatic send_word(input logic act, input logic [7:0] b);
    @(negedge clk);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    action    <= act;
    midi_byte <= b;
    do @(posedge clk); while (!in_ready);
    words_sent++;
  endtask

  task automatic release_input();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic write_register(input logic [mct_pkg::CIDX_W-1:0] idx,
                                input logic [31:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (expected_events.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic send_group(input int base, input int jitter_pct, input int stop_at);
    int iv;
    for (int p = 0; p < PPQ; p++) begin
      if (words_sent >= stop_at) return;
      iv = base;
      if ($urandom_range(99) < jitter_pct) iv = base + int'($urandom_range(2)) - 1;
      if (iv < 0) iv = 0;
      repeat (iv) send_word(mct_pkg::ACT_TICK, 8'($urandom));
      if ($urandom_range(99) < 4)
        send_word(mct_pkg::ACT_BYTE,
                  ($urandom_range(1) == 0) ? mct_pkg::MIDI_START : 8'($urandom));
      send_word(mct_pkg::ACT_BYTE, mct_pkg::MIDI_CLOCK);
    end
  endtask

  task automatic test_zero_interval_group();
    write_register(mct_pkg::REG_NEEDED, {29'($urandom), 3'd0});
    repeat (PPQ) send_word(mct_pkg::ACT_BYTE, mct_pkg::MIDI_CLOCK);
  endtask

  task automatic test_transport_bytes();
    release_input();
    wait_drained();
    write_register(REG_UNUSED, $urandom);
    send_word(mct_pkg::ACT_BYTE, mct_pkg::MIDI_START);
    send_word(mct_pkg::ACT_BYTE, 8'hFB);
    send_word(mct_pkg::ACT_BYTE, 8'hFC);
    send_word(mct_pkg::ACT_BYTE, 8'h00);
    send_word(mct_pkg::ACT_BYTE, 8'hFF);
    send_word(mct_pkg::ACT_BYTE, 8'h7F);
    send_word(mct_pkg::ACT_TICK, 8'hFF);
    send_word(mct_pkg::ACT_TICK, 8'h00);
    send_word(mct_pkg::ACT_BYTE, mct_pkg::MIDI_START);
  endtask

  task automatic test_tempo_tracking(input int tx_pct, input int rx_pct,
                                     input logic [mct_pkg::TPS_W-1:0] tps,
                                     input logic [mct_pkg::WIN_W-1:0] win,
                                     input logic [mct_pkg::NEED_W-1:0] need,
                                     input int word_budget);
    logic [31:0] data;
    int          stop_at;
    int          base;
    int          jitter;
    release_input();
    wait_drained();
    data = $urandom;
    data[mct_pkg::TPS_W-1:0] = tps;
    write_register(mct_pkg::REG_TPS, data);
    write_register(mct_pkg::REG_WINDOW, {24'($urandom), win});
    write_register(mct_pkg::REG_NEEDED, {29'($urandom), need});
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    stop_at     = words_sent + word_budget;
    while (words_sent < stop_at) begin
      if ($urandom_range(99) < 8) begin
        repeat ($urandom_range(4, 12)) send_word(1'($urandom), 8'($urandom));
      end else begin
        base   = ($urandom_range(9) == 0) ? 0 : int'($urandom_range(1, 6));
        jitter = ($urandom_range(1) == 0) ? 0 : 10;
        repeat ($urandom_range(2, 6)) send_group(base, jitter, stop_at);
      end
    end
  endtask

  task automatic test_output_backpressure();
    release_input();
    wait_drained();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    @(posedge clk);
    hold_left = HOLD_CYCLES;
    repeat (20) begin
      send_word(mct_pkg::ACT_BYTE, mct_pkg::MIDI_START);
      send_word(mct_pkg::ACT_TICK, 8'($urandom));
    end
  endtask

  initial begin
    reset_tempo_model();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    tx_idle_pct = 23;
    rx_idle_pct = 82;
    test_zero_interval_group();
    test_transport_bytes();
    test_tempo_tracking(23, 82, 27'd1000, 8'd0, 3'd1, 190);
    test_tempo_tracking(82, 23, mct_pkg::TPS_W'($urandom_range(1000, 3000)), 8'd255, 3'd2,
                        190);
    test_tempo_tracking(0, 0, 27'd100000000, 8'($urandom), 3'd7, 150);
    test_tempo_tracking(0, 0, mct_pkg::TPS_W'($urandom_range(1000, 4000)), 8'($urandom),
                        mct_pkg::NEED_W'($urandom_range(0, 7)), 150);
    test_output_backpressure();
    release_input();
    wait_drained();
    if (errors == 0 && expected_events.size() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
